@@ src/positional_sequential_list_top_macros.svh @@
// Assertion macros for the positional list block.
`ifndef POSITIONAL_SEQUENTIAL_LIST_TOP_MACROS_SVH
`define POSITIONAL_SEQUENTIAL_LIST_TOP_MACROS_SVH
`ifndef SYNTHESIS
// check with reset as disable
`define PLS_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// check that also holds while reset is high
`define PLS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PLS_ASSERT(lbl, clk, rst, prop, msg)
`define PLS_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

@@ src/pls_pkg.sv @@
// Types, codes and microcode table for the positional list block.
package pls_pkg;

   localparam int CAPACITY_DEF = 16;
   localparam int POS_W        = 5;
   localparam int VAL_W        = 32;

   typedef enum logic [1:0] {
      K_INSERT = 2'd0,
      K_DELETE = 2'd1,
      K_GET    = 2'd2,
      K_LOCATE = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_FULL     = 2'd1,
      ST_BADPOS   = 2'd2,
      ST_NOTFOUND = 2'd3
   } status_type;

   // microcode step addresses
   typedef enum logic [3:0] {
      U_IDLE     = 4'd0,
      U_INS_FULL = 4'd1,
      U_INS_POS  = 4'd2,
      U_INS_LOOP = 4'd3,
      U_INS_MOVE = 4'd4,
      U_INS_PUT  = 4'd5,
      U_DEL_CHK  = 4'd6,
      U_DEL_GET  = 4'd7,
      U_DEL_LOOP = 4'd8,
      U_DEL_MOVE = 4'd9,
      U_DEL_END  = 4'd10,
      U_GET_CHK  = 4'd11,
      U_GET_RD   = 4'd12,
      U_LOC_LOOP = 4'd13,
      U_LOC_CMP  = 4'd14,
      U_FIN      = 4'd15
   } upc_type;

   typedef enum logic [1:0] {
      SEQ_STEP     = 2'd0,
      SEQ_DISPATCH = 2'd1,
      SEQ_RETIRE   = 2'd2
   } seq_type;

   typedef enum logic [2:0] {
      COND_NEVER      = 3'd0,
      COND_FULL       = 3'd1,
      COND_BAD_INS    = 3'd2,
      COND_BAD_POS    = 3'd3,
      COND_IDX_LT_POS = 3'd4,
      COND_IDX_GE_CNT = 3'd5,
      COND_MATCH      = 3'd6
   } cond_type;

   typedef enum logic [1:0] {
      RD_NONE   = 2'd0,
      RD_IDX    = 2'd1,
      RD_IDX_M1 = 2'd2,
      RD_POS_M1 = 2'd3
   } rd_type;

   typedef enum logic [1:0] {
      WR_NONE        = 2'd0,
      WR_IDX_RDATA   = 2'd1,
      WR_IDXM1_RDATA = 2'd2,
      WR_POSM1_VALUE = 2'd3
   } wr_type;

   typedef enum logic [2:0] {
      IDX_HOLD  = 3'd0,
      IDX_COUNT = 3'd1,
      IDX_POS   = 3'd2,
      IDX_DEC   = 3'd3,
      IDX_INC   = 3'd4
   } idx_type;

   typedef enum logic [1:0] {
      CNT_HOLD = 2'd0,
      CNT_INC  = 2'd1,
      CNT_DEC  = 2'd2
   } cnt_type;

   // taken: st/found fire, go nxt_t; else: rd/wr/idx/cnt/rdv fire, go nxt_f
   typedef struct packed {
      seq_type    seq;
      cond_type   cond;
      upc_type    nxt_t;
      upc_type    nxt_f;
      logic       st_en;
      status_type st;
      logic       found_en;
      rd_type     rd;
      wr_type     wr;
      idx_type    idx;
      cnt_type    cnt;
      logic       rdv_ld;
   } ucode_type;

   function automatic ucode_type ucode(upc_type a);
      ucode_type w;
      w = '{seq: SEQ_STEP, cond: COND_NEVER, nxt_t: U_FIN, nxt_f: U_FIN,
            st_en: 1'b0, st: ST_OK, found_en: 1'b0, rd: RD_NONE, wr: WR_NONE,
            idx: IDX_HOLD, cnt: CNT_HOLD, rdv_ld: 1'b0};
      case (a)
         U_IDLE: begin
            w.seq = SEQ_DISPATCH;
         end
         U_INS_FULL: begin
            w.cond = COND_FULL;  w.st_en = 1'b1;  w.st = ST_FULL;
            w.nxt_f = U_INS_POS;
         end
         U_INS_POS: begin
            w.cond = COND_BAD_INS;  w.st_en = 1'b1;  w.st = ST_BADPOS;
            w.idx = IDX_COUNT;  w.nxt_f = U_INS_LOOP;
         end
         U_INS_LOOP: begin
            w.cond = COND_IDX_LT_POS;  w.nxt_t = U_INS_PUT;
            w.rd = RD_IDX_M1;  w.nxt_f = U_INS_MOVE;
         end
         U_INS_MOVE: begin
            w.wr = WR_IDX_RDATA;  w.idx = IDX_DEC;  w.nxt_f = U_INS_LOOP;
         end
         U_INS_PUT: begin
            w.wr = WR_POSM1_VALUE;  w.cnt = CNT_INC;
         end
         U_DEL_CHK: begin
            w.cond = COND_BAD_POS;  w.st_en = 1'b1;  w.st = ST_BADPOS;
            w.rd = RD_POS_M1;  w.idx = IDX_POS;  w.nxt_f = U_DEL_GET;
         end
         U_DEL_GET: begin
            w.rdv_ld = 1'b1;  w.nxt_f = U_DEL_LOOP;
         end
         U_DEL_LOOP: begin
            w.cond = COND_IDX_GE_CNT;  w.nxt_t = U_DEL_END;
            w.rd = RD_IDX;  w.nxt_f = U_DEL_MOVE;
         end
         U_DEL_MOVE: begin
            w.wr = WR_IDXM1_RDATA;  w.idx = IDX_INC;  w.nxt_f = U_DEL_LOOP;
         end
         U_DEL_END: begin
            w.cnt = CNT_DEC;
         end
         U_GET_CHK: begin
            w.cond = COND_BAD_POS;  w.st_en = 1'b1;  w.st = ST_BADPOS;
            w.rd = RD_POS_M1;  w.nxt_f = U_GET_RD;
         end
         U_GET_RD: begin
            w.rdv_ld = 1'b1;
         end
         U_LOC_LOOP: begin
            w.cond = COND_IDX_GE_CNT;
            w.rd = RD_IDX;  w.nxt_f = U_LOC_CMP;
         end
         U_LOC_CMP: begin
            w.cond = COND_MATCH;  w.st_en = 1'b1;  w.st = ST_OK;
            w.found_en = 1'b1;
            w.idx = IDX_INC;  w.nxt_f = U_LOC_LOOP;
         end
         U_FIN: begin
            w.seq = SEQ_RETIRE;
         end
         default: begin
            w.seq = SEQ_RETIRE;
         end
      endcase
      return w;
   endfunction

endpackage

@@ src/pls_store.sv @@
// Entry store: one write port, one registered read port.
module pls_store #(
   parameter int DEPTH = pls_pkg::CAPACITY_DEF,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [AW-1:0]            wr_addr,
   input  logic [pls_pkg::VAL_W-1:0] wr_data,
   input  logic                     rd_en,
   input  logic [AW-1:0]            rd_addr,
   output logic [pls_pkg::VAL_W-1:0] rd_data
);

   logic [pls_pkg::VAL_W-1:0] mem [DEPTH];
   logic [pls_pkg::VAL_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/positional_sequential_list_top.sv @@
// Top level of the positional list: microcoded sequencer, entry store and result register.
//
// Fixed-capacity ordered list of signed 32-bit words addressed by 1-based position.
// Request channel (req_*): one word per request; req_tuser is the kind
// (insert, delete, get, locate), req_tdata carries position and value.
// Response channel (rsp_*): exactly one word per request, in order; rsp_tuser
// is the status, rsp_tdata carries read value, found position and length.
// An insert checks for a full list before its position; delete and get check the
// position first; locate compares entries from the first on and stops at the first match.
// The sequencer handles one request at a time; moves and compares go one entry
// at a time, a read step then a move or compare step, as the store read is registered.
// A new request is taken while the previous response still waits in the
// output register; a stalled receiver holds the response, and the sequencer
// waits at its final step until the register frees up.
// Reset (synchronous, active high) empties the list and drops any pending
// response; stored entries are not cleared and are never read before written.
`include "positional_sequential_list_top_macros.svh"

module positional_sequential_list_top #(
   parameter int CAPACITY = pls_pkg::CAPACITY_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // [4:0] position, [36:5] value, [39:37] zero
   input  logic [1:0]  req_tuser,   // [1:0] req_type
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // [31:0] read_value, [36:32] found_position,
                                    // [41:37] list_length, [47:42] zero
   output logic [1:0]  rsp_tuser    // [1:0] status
);

   localparam int CW   = $clog2(CAPACITY + 1);
   localparam int AW   = $clog2(CAPACITY);
   localparam int CMPW = ((CW > pls_pkg::POS_W) ? CW : pls_pkg::POS_W) + 1;
   localparam int PW   = pls_pkg::POS_W;
   localparam int VW   = pls_pkg::VAL_W;

   // sequencer state
   pls_pkg::upc_type   upc_ff, upc_in;
   pls_pkg::ucode_type ctl;
   logic               taken;

   // datapath registers
   logic [CW-1:0]       count_ff, count_in;
   logic [CW-1:0]       idx_ff, idx_in;
   logic [PW-1:0]       pos_ff, pos_in;
   logic [VW-1:0]       val_ff, val_in;
   pls_pkg::status_type status_ff, status_in;
   logic [VW-1:0]       rdv_ff, rdv_in;
   logic [PW-1:0]       found_ff, found_in;

   // response register
   logic                rsp_valid_ff, rsp_valid_in;
   pls_pkg::status_type rsp_status_ff, rsp_status_in;
   logic [VW-1:0]       rsp_rdv_ff, rsp_rdv_in;
   logic [PW-1:0]       rsp_found_ff, rsp_found_in;
   logic [PW-1:0]       rsp_len_ff, rsp_len_in;

   // store port
   logic          st_wr_en, st_rd_en;
   logic [AW-1:0] st_wr_addr, st_rd_addr;
   logic [VW-1:0] st_wr_data, st_rd_data;

   logic            req_fire, out_free;
   logic [CMPW-1:0] cnt_x, idx_x, pos_x, idx_m1_x, pos_m1_x, idx_p1_x;

   assign ctl        = pls_pkg::ucode(upc_ff);
   assign req_tready = (ctl.seq == pls_pkg::SEQ_DISPATCH);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign cnt_x    = CMPW'(count_ff);
   assign idx_x    = CMPW'(idx_ff);
   assign pos_x    = CMPW'(pos_ff);
   assign idx_m1_x = idx_x - CMPW'(1);
   assign pos_m1_x = pos_x - CMPW'(1);
   assign idx_p1_x = idx_x + CMPW'(1);

   // branch condition
   always_comb begin
      case (ctl.cond)
         pls_pkg::COND_NEVER:      taken = 1'b0;
         pls_pkg::COND_FULL:       taken = (cnt_x == CMPW'(CAPACITY));
         pls_pkg::COND_BAD_INS:    taken = (pos_x == '0) || (pos_x > cnt_x + CMPW'(1));
         pls_pkg::COND_BAD_POS:    taken = (pos_x == '0) || (pos_x > cnt_x);
         pls_pkg::COND_IDX_LT_POS: taken = (idx_x < pos_x);
         pls_pkg::COND_IDX_GE_CNT: taken = (idx_x >= cnt_x);
         pls_pkg::COND_MATCH:      taken = (st_rd_data == val_ff);
         default:                  taken = 1'b0;
      endcase
   end

   // next step
   always_comb begin
      upc_in = upc_ff;
      case (ctl.seq)
         pls_pkg::SEQ_DISPATCH: begin
            if (req_fire) begin
               case (pls_pkg::kind_type'(req_tuser))
                  pls_pkg::K_INSERT: upc_in = pls_pkg::U_INS_FULL;
                  pls_pkg::K_DELETE: upc_in = pls_pkg::U_DEL_CHK;
                  pls_pkg::K_GET:    upc_in = pls_pkg::U_GET_CHK;
                  default:           upc_in = pls_pkg::U_LOC_LOOP;
               endcase
            end
         end
         pls_pkg::SEQ_RETIRE: begin
            if (out_free) begin
               upc_in = pls_pkg::U_IDLE;
            end
         end
         default: begin
            upc_in = taken ? ctl.nxt_t : ctl.nxt_f;
         end
      endcase
   end

   // datapath control from the current control word
   always_comb begin
      count_in      = count_ff;
      idx_in        = idx_ff;
      pos_in        = pos_ff;
      val_in        = val_ff;
      status_in     = status_ff;
      rdv_in        = rdv_ff;
      found_in      = found_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_rdv_in    = rsp_rdv_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_len_in    = rsp_len_ff;
      st_wr_en      = 1'b0;
      st_wr_addr    = idx_x[AW-1:0];
      st_wr_data    = st_rd_data;
      st_rd_en      = 1'b0;
      st_rd_addr    = idx_x[AW-1:0];

      if (req_fire) begin
         pos_in    = req_tdata[PW-1:0];
         val_in    = req_tdata[PW+VW-1:PW];
         idx_in    = '0;
         rdv_in    = '0;
         found_in  = '0;
         status_in = (pls_pkg::kind_type'(req_tuser) == pls_pkg::K_LOCATE) ?
                     pls_pkg::ST_NOTFOUND : pls_pkg::ST_OK;
      end

      if (ctl.seq == pls_pkg::SEQ_RETIRE && out_free) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = status_ff;
         rsp_rdv_in    = rdv_ff;
         rsp_found_in  = found_ff;
         rsp_len_in    = cnt_x[PW-1:0];
      end

      if (ctl.seq == pls_pkg::SEQ_STEP) begin
         if (taken) begin
            if (ctl.st_en) begin
               status_in = ctl.st;
            end
            if (ctl.found_en) begin
               found_in = idx_p1_x[PW-1:0];
            end
         end else begin
            case (ctl.rd)
               pls_pkg::RD_IDX: begin
                  st_rd_en = 1'b1;  st_rd_addr = idx_x[AW-1:0];
               end
               pls_pkg::RD_IDX_M1: begin
                  st_rd_en = 1'b1;  st_rd_addr = idx_m1_x[AW-1:0];
               end
               pls_pkg::RD_POS_M1: begin
                  st_rd_en = 1'b1;  st_rd_addr = pos_m1_x[AW-1:0];
               end
               default: ;
            endcase
            case (ctl.wr)
               pls_pkg::WR_IDX_RDATA: begin
                  st_wr_en = 1'b1;  st_wr_addr = idx_x[AW-1:0];
               end
               pls_pkg::WR_IDXM1_RDATA: begin
                  st_wr_en = 1'b1;  st_wr_addr = idx_m1_x[AW-1:0];
               end
               pls_pkg::WR_POSM1_VALUE: begin
                  st_wr_en = 1'b1;  st_wr_addr = pos_m1_x[AW-1:0];
                  st_wr_data = val_ff;
               end
               default: ;
            endcase
            case (ctl.idx)
               pls_pkg::IDX_COUNT: idx_in = count_ff;
               pls_pkg::IDX_POS:   idx_in = pos_x[CW-1:0];
               pls_pkg::IDX_DEC:   idx_in = idx_m1_x[CW-1:0];
               pls_pkg::IDX_INC:   idx_in = idx_p1_x[CW-1:0];
               default: ;
            endcase
            case (ctl.cnt)
               pls_pkg::CNT_INC: count_in = count_ff + CW'(1);
               pls_pkg::CNT_DEC: count_in = count_ff - CW'(1);
               default: ;
            endcase
            if (ctl.rdv_ld) begin
               rdv_in = st_rd_data;
            end
         end
      end
   end

   pls_store #(
      .DEPTH (CAPACITY),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (st_wr_en),
      .wr_addr (st_wr_addr),
      .wr_data (st_wr_data),
      .rd_en   (st_rd_en),
      .rd_addr (st_rd_addr),
      .rd_data (st_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff       <= pls_pkg::U_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         upc_ff       <= upc_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      pos_ff        <= pos_in;
      val_ff        <= val_in;
      status_ff     <= status_in;
      rdv_ff        <= rdv_in;
      found_ff      <= found_in;
      rsp_status_ff <= rsp_status_in;
      rsp_rdv_ff    <= rsp_rdv_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_len_ff    <= rsp_len_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {6'b0, rsp_len_ff, rsp_found_ff, rsp_rdv_ff};

   // list never overfills
   `PLS_ASSERT(a_count_cap, clock, reset, (count_ff <= CW'(CAPACITY)), "count above capacity")
   // one request at a time
   `PLS_ASSERT(a_one_busy, clock, reset, (req_fire |=> !req_tready), "request taken while busy")
   // responses only come out of the final step
   `PLS_ASSERT(a_rsp_src, clock, reset, (($rose(rsp_valid_ff) && !$past(reset)) |-> ($past(upc_ff) == pls_pkg::U_FIN)), "response without retire")
   // length moves only at the insert and delete commit steps
   `PLS_ASSERT(a_count_step, clock, reset, (((count_ff != $past(count_ff)) && !$past(reset)) |-> ($past(upc_ff) == pls_pkg::U_INS_PUT || $past(upc_ff) == pls_pkg::U_DEL_END)), "length changed outside commit")
   // reset returns to idle with nothing pending
   `PLS_ASSERT_ALWAYS(a_reset_idle, clock, (reset |=> (upc_ff == pls_pkg::U_IDLE && !rsp_valid_ff)), "reset did not idle")

endmodule

@@ verif/positional_sequential_list_checker.sv @@
// Monitor and scoreboard for the positional list: predicts each response and compares it.
module positional_sequential_list_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [39:0] req_tdata,
   input  logic [1:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [47:0] rsp_tdata,
   input  logic [1:0]  rsp_tuser,
   output int          mismatches,
   output int          outstanding,
   output int          list_len
);

   typedef struct packed {
      pls_pkg::status_type status;
      logic [31:0]         read_value;
      logic [4:0]          found_pos;
      logic [4:0]          length;
   } list_reply_type;

   list_reply_type replies_due[$];
   logic [31:0]    slots[pls_pkg::CAPACITY_DEF];
   int             fill = 0;
   int             errors = 0;

   assign mismatches = errors;

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("ERROR: %s: got %0h, expected %0h", what, got, want);
      errors++;
   endtask

   // Applies one request to the shadow list and returns the response it owes.
   function automatic list_reply_type apply_request(input pls_pkg::kind_type kind,
                                                    input int pos,
                                                    input logic [31:0] val);
      list_reply_type r;
      r = '{status: pls_pkg::ST_OK, read_value: '0, found_pos: '0, length: '0};
      case (kind)
         pls_pkg::K_INSERT: begin
            if (fill >= pls_pkg::CAPACITY_DEF) begin
               r.status = pls_pkg::ST_FULL;
            end else if (pos < 1 || pos > fill + 1) begin
               r.status = pls_pkg::ST_BADPOS;
            end else begin
               for (int i = fill; i >= pos; i--) slots[i] = slots[i - 1];
               slots[pos - 1] = val;
               fill++;
            end
         end
         pls_pkg::K_DELETE: begin
            if (pos < 1 || pos > fill) begin
               r.status = pls_pkg::ST_BADPOS;
            end else begin
               r.read_value = slots[pos - 1];
               for (int i = pos; i < fill; i++) slots[i - 1] = slots[i];
               fill--;
            end
         end
         pls_pkg::K_GET: begin
            if (pos < 1 || pos > fill) r.status = pls_pkg::ST_BADPOS;
            else r.read_value = slots[pos - 1];
         end
         default: begin
            r.status = pls_pkg::ST_NOTFOUND;
            for (int i = 0; i < fill; i++) begin
               if (slots[i] == val) begin
                  r.status    = pls_pkg::ST_OK;
                  r.found_pos = 5'(i + 1);
                  break;
               end
            end
         end
      endcase
      r.length = 5'(fill);
      return r;
   endfunction

   always @(posedge clock) begin
      list_reply_type want;
      if (reset) begin
         fill = 0;
         replies_due.delete();
      end else begin
         // response first: it can never belong to a request taken at this edge
         if (rsp_tvalid && rsp_tready) begin
            if (replies_due.size() == 0) begin
               report_mismatch("response with none pending", rsp_tdata[31:0], '0);
            end else begin
               want = replies_due.pop_front();
               if (rsp_tuser != want.status)
                  report_mismatch("status", 32'(rsp_tuser), 32'(want.status));
               if (rsp_tdata[31:0] != want.read_value)
                  report_mismatch("read_value", rsp_tdata[31:0], want.read_value);
               if (rsp_tdata[36:32] != want.found_pos)
                  report_mismatch("found_position", 32'(rsp_tdata[36:32]),
                                  32'(want.found_pos));
               if (rsp_tdata[41:37] != want.length)
                  report_mismatch("list_length", 32'(rsp_tdata[41:37]),
                                  32'(want.length));
            end
         end
         if (req_tvalid && req_tready)
            replies_due.push_back(apply_request(pls_pkg::kind_type'(req_tuser),
                                                int'(req_tdata[4:0]), req_tdata[36:5]));
      end
      outstanding <= replies_due.size();
      list_len    <= fill;
   end

endmodule

@@ verif/positional_sequential_list_top_tb.sv @@
// Testbench top for the positional list: clock, reset, stimulus, flow control and verdict.
module positional_sequential_list_top_tb;

   localparam int RUN_LIMIT    = 600000;
   localparam int RANDOM_WORDS = 850;
   localparam int DRAIN_CYCLES = 60;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata  = '0;                // [4:0] position, [36:5] value, [39:37] zero
   logic [1:0]  req_tuser  = pls_pkg::K_INSERT; // [1:0] req_type
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;             // [31:0] read_value, [36:32] found_position,
                                       // [41:37] list_length, [47:42] zero
   logic [1:0]  rsp_tuser;             // [1:0] status

   int          mismatches;
   int          outstanding;
   int          list_len;
   int          cycles     = 0;
   int          calm_words = 0;        // words left in a no-gap stretch
   int          ready_hold = 0;        // cycles the current tready level is kept
   logic        filling    = 1'b1;     // bias toward growing or shrinking the list
   logic [31:0] pool[8];               // small value set so locates hit and repeat

   always #5 clock = ~clock;

   positional_sequential_list_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   positional_sequential_list_checker i_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .mismatches  (mismatches),
      .outstanding (outstanding),
      .list_len    (list_len)
   );

   // Watchdog: a hang or a lost response ends here.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= RUN_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Receiver backpressure: each level is held for a random run. Ready runs are
   // sometimes long (stall-free stretches), stall runs are mostly short.
   always @(posedge clock) begin
      if (ready_hold > 0) begin
         ready_hold <= ready_hold - 1;
      end else if ($urandom_range(0, 99) < 60) begin
         rsp_tready <= 1'b1;
         ready_hold <= ($urandom_range(0, 19) == 0) ? $urandom_range(30, 80)
                                                   : $urandom_range(0, 6);
      end else begin
         rsp_tready <= 1'b0;
         ready_hold <= ($urandom_range(0, 14) == 0) ? $urandom_range(10, 40)
                                                   : $urandom_range(0, 3);
      end
   end

   // Presents one request word and returns at the edge where it is taken.
   // tvalid stays high into the next word unless a gap is drawn.
   task automatic send_word(input pls_pkg::kind_type kind, input int pos,
                            input logic [31:0] val);
      int gap;
      if (calm_words > 0) begin
         calm_words--;
         gap = 0;
      end else if ($urandom_range(0, 49) == 0) begin
         calm_words = $urandom_range(20, 60);
         gap = 0;
      end else if ($urandom_range(0, 19) == 0) begin
         gap = $urandom_range(10, 40);
      end else if ($urandom_range(0, 9) < 4) begin
         gap = $urandom_range(1, 3);
      end else begin
         gap = 0;
      end
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {3'b000, val, 5'(pos)};
      do @(posedge clock); while (!req_tready);
   endtask

   initial begin
      pool[0] = 32'h8000_0000;
      pool[1] = 32'h7fff_ffff;
      pool[2] = 32'h0000_0000;
      pool[3] = 32'hffff_ffff;
      for (int i = 4; i < 8; i++) pool[i] = $urandom;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // ---- directed part ----
      // empty list: every get, delete and locate is refused
      send_word(pls_pkg::K_GET, 1, 32'h0);
      send_word(pls_pkg::K_DELETE, 1, 32'h0);
      send_word(pls_pkg::K_LOCATE, 0, 32'h0);
      // insert outside 1..length+1
      send_word(pls_pkg::K_INSERT, 0, 32'h1234_5678);
      send_word(pls_pkg::K_INSERT, 2, 32'h1234_5678);
      // build -1, min, max
      send_word(pls_pkg::K_INSERT, 1, 32'h8000_0000);
      send_word(pls_pkg::K_INSERT, 2, 32'h7fff_ffff);
      send_word(pls_pkg::K_INSERT, 1, 32'hffff_ffff);
      send_word(pls_pkg::K_LOCATE, 31, 32'h7fff_ffff);
      send_word(pls_pkg::K_LOCATE, 0, 32'hffff_ffff);
      send_word(pls_pkg::K_GET, 31, 32'h0);
      send_word(pls_pkg::K_GET, 3, 32'hffff_ffff);
      // delete from the middle, then past the end
      send_word(pls_pkg::K_DELETE, 2, 32'h0);
      send_word(pls_pkg::K_DELETE, 3, 32'h0);
      // fill to capacity by appending
      for (int p = 3; p <= pls_pkg::CAPACITY_DEF; p++)
         send_word(pls_pkg::K_INSERT, p, $urandom);
      // full list: full wins over a bad position
      send_word(pls_pkg::K_INSERT, 0, 32'h5555_aaaa);
      send_word(pls_pkg::K_INSERT, 17, 32'h5555_aaaa);
      send_word(pls_pkg::K_LOCATE, 7, 32'h8000_0000);
      // delete the top entry and the first
      send_word(pls_pkg::K_DELETE, pls_pkg::CAPACITY_DEF, 32'h0);
      send_word(pls_pkg::K_DELETE, 1, 32'hffff_ffff);

      // ---- random part ----
      // list length swings between empty and full; positions are mostly legal
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         int                roll;
         int                len;
         int                pos;
         pls_pkg::kind_type kind;
         logic [31:0]       val;
         len = list_len;  // may trail the words in flight; only steers the mix
         if (len >= pls_pkg::CAPACITY_DEF - 1) filling = 1'b0;
         else if (len <= 1) filling = 1'b1;
         roll = $urandom_range(0, 99);
         if (roll < (filling ? 50 : 15)) kind = pls_pkg::K_INSERT;
         else if (roll < 65) kind = pls_pkg::K_DELETE;
         else if (roll < 80) kind = pls_pkg::K_GET;
         else kind = pls_pkg::K_LOCATE;
         if ($urandom_range(0, 6) == 0) pos = $urandom_range(0, 31);
         else if (kind == pls_pkg::K_INSERT) pos = $urandom_range(1, len + 1);
         else pos = $urandom_range(1, (len > 0) ? len : 1);
         val = ($urandom_range(0, 9) < 6) ? pool[3'($urandom_range(0, 7))] : $urandom;
         send_word(kind, pos, val);
      end

      // the last word was taken at this edge; drop valid before the next one
      req_tvalid <= 1'b0;
      @(posedge clock);
      wait (outstanding == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
